>>> rtl/tbeg_pkg.sv
// Shared constants and types for the two-body effective gravity block.
// No dependencies; used by every module under rtl.
package tbeg_pkg;

    localparam int COORD_WIDTH     = 16;
    localparam int RESULT_WIDTH    = 32;
    localparam int CFG_WIDTH       = 16;
    localparam int CFG_INDEX_WIDTH = 2;

    // register indexes on the configuration port
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MASS_ONE   = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MASS_TWO   = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SEPARATION = 2'd2;

    localparam int MASS_W = 16;
    localparam int POS_W  = 17;
    localparam int SPIN_W = 48;
    localparam logic [SPIN_W-1:0] SPIN_MAX = '1;

    // squared distance, 24 fraction bits, and the floor standing for 1e-6
    localparam int DSQ_W = 35;
    localparam logic [DSQ_W-1:0] DIST_FLOOR = 35'd17;

    // inverse distance and inverse cube, 32 fraction bits
    localparam int ROOT_W = 26;
    localparam int INV_W  = 42;
    localparam int IR3_W  = 62;

    localparam int ISQ_STAGES = ROOT_W;
    localparam int DIV_STAGES = INV_W / 2;
    localparam int INV_LAT    = ISQ_STAGES + DIV_STAGES + 4;

    typedef struct packed {
        logic [MASS_W-1:0]        m1;
        logic [MASS_W-1:0]        m2;
        logic signed [POS_W-1:0]  body_one_x;
        logic signed [POS_W-1:0]  body_two_x;
        logic [SPIN_W-1:0]        spin;
    } geom_t;

endpackage

>>> rtl/two_body_effective_gravity.sv
// Top level: effective potential and gravity of two bodies in the co-rotating frame.
// Depends on tbeg_pkg, tbeg_cfg and tbeg_invdist.
//
//  channel   handshake             payload
//  input     start / busy          point_x, point_y
//  result    done (one cycle)      potential, accel_x, accel_y, saturated
//  config    cfg_write             cfg_index, cfg_data
//
// One point enters per clock while busy is low; done rises once the result has passed
// the per-bit root and reciprocal stages of the inverse-distance pipe.
// A register write holds busy high while the derivation sequencer divides out body
// positions and spin; reset leaves them zero and busy low.
// The receiver cannot stall, so valid bits advance every cycle.
module two_body_effective_gravity import tbeg_pkg::*; (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic signed [COORD_WIDTH-1:0]  point_x,
    input  logic signed [COORD_WIDTH-1:0]  point_y,
    input  logic                           cfg_write,
    input  logic [CFG_INDEX_WIDTH-1:0]     cfg_index,
    input  logic [CFG_WIDTH-1:0]           cfg_data,
    output logic                           done,
    output logic signed [RESULT_WIDTH-1:0] potential,
    output logic signed [RESULT_WIDTH-1:0] accel_x,
    output logic signed [RESULT_WIDTH-1:0] accel_y,
    output logic                           saturated
);

    typedef struct packed {
        logic [32:0] md1;
        logic [32:0] md2;
        logic [31:0] my1;
        logic [31:0] my2;
        logic [34:0] gxs;
        logic [34:0] gys;
        logic [31:0] rsq;
        logic        sx1;
        logic        sx2;
        logic        sxn;
        logic        syp;
        logic        syn;
    } side_t;

    localparam logic signed [63:0] RES_MAX = (64'sd1 <<< (RESULT_WIDTH - 1)) - 64'sd1;
    localparam logic signed [63:0] RES_MIN = -RES_MAX - 64'sd1;

    function automatic logic [RESULT_WIDTH:0] clip(input logic signed [63:0] v);
        logic [RESULT_WIDTH:0] r;
        if (v > RES_MAX)
        begin
            r = {1'b1, RES_MAX[RESULT_WIDTH-1:0]};
        end
        else if (v < RES_MIN)
        begin
            r = {1'b1, RES_MIN[RESULT_WIDTH-1:0]};
        end
        else
        begin
            r = {1'b0, v[RESULT_WIDTH-1:0]};
        end
        return r;
    endfunction

    geom_t geom;
    logic  accept;

    tbeg_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .busy      (busy),
        .geom      (geom)
    );

    assign accept = start && !busy;

    // P0: input register
    logic [15:0] x0_reg, y0_reg;
    logic        v0_reg;

    // P1: offsets and magnitudes
    logic [17:0] xe, b1e, b2e, dx1, dx2, ndx1, ndx2;
    logic [16:0] xe17, ye17, nx17, ny17;
    logic [16:0] d1_reg, d2_reg;
    logic [15:0] xm_reg, ym_reg;
    logic        sx1_p1_reg, sx2_p1_reg, sxn_p1_reg, syp_p1_reg, syn_p1_reg;
    logic        v1_reg;

    assign xe   = {{2{x0_reg[15]}}, x0_reg};
    assign b1e  = {geom.body_one_x[POS_W-1], geom.body_one_x};
    assign b2e  = {geom.body_two_x[POS_W-1], geom.body_two_x};
    assign dx1  = xe - b1e;
    assign dx2  = xe - b2e;
    assign ndx1 = 18'd0 - dx1;
    assign ndx2 = 18'd0 - dx2;
    assign xe17 = {x0_reg[15], x0_reg};
    assign ye17 = {y0_reg[15], y0_reg};
    assign nx17 = 17'd0 - xe17;
    assign ny17 = 17'd0 - ye17;

    // P2: squares and narrow products
    logic [33:0] d1sq_reg, d2sq_reg;
    logic [31:0] xsq_reg, ysq_reg;
    logic [32:0] md1_reg, md2_reg;
    logic [31:0] my1_reg, my2_reg;
    logic [39:0] sxl_reg, sxh_reg, syl_reg, syh_reg;
    logic        sx1_p2_reg, sx2_p2_reg, sxn_p2_reg, syp_p2_reg, syn_p2_reg;
    logic        v2_reg;

    // P3: squared distances into the inverse pipe
    logic [DSQ_W-1:0] r1_sum, r2_sum;
    logic [DSQ_W-1:0] r1_reg, r2_reg;
    logic [63:0]      gx_spin_full, gy_spin_full;
    logic             v3_reg;
    side_t            side_reg[0:INV_LAT];

    assign r1_sum       = 35'(d1sq_reg) + 35'(ysq_reg);
    assign r2_sum       = 35'(d2sq_reg) + 35'(ysq_reg);
    assign gx_spin_full = (64'(sxh_reg) << 24) + 64'(sxl_reg);
    assign gy_spin_full = (64'(syh_reg) << 24) + 64'(syl_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= accept;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x0_reg <= point_x;
            y0_reg <= point_y;
        end

        d1_reg     <= dx1[17] ? ndx1[16:0] : dx1[16:0];
        d2_reg     <= dx2[17] ? ndx2[16:0] : dx2[16:0];
        xm_reg     <= x0_reg[15] ? nx17[15:0] : x0_reg;
        ym_reg     <= y0_reg[15] ? ny17[15:0] : y0_reg;
        sx1_p1_reg <= !dx1[17] && (dx1 != 18'd0);
        sx2_p1_reg <= !dx2[17] && (dx2 != 18'd0);
        sxn_p1_reg <= x0_reg[15];
        syp_p1_reg <= !y0_reg[15] && (y0_reg != 16'd0);
        syn_p1_reg <= y0_reg[15];

        d1sq_reg   <= d1_reg * d1_reg;
        d2sq_reg   <= d2_reg * d2_reg;
        xsq_reg    <= xm_reg * xm_reg;
        ysq_reg    <= ym_reg * ym_reg;
        md1_reg    <= geom.m1 * d1_reg;
        md2_reg    <= geom.m2 * d2_reg;
        my1_reg    <= geom.m1 * ym_reg;
        my2_reg    <= geom.m2 * ym_reg;
        sxl_reg    <= geom.spin[23:0] * xm_reg;
        sxh_reg    <= geom.spin[47:24] * xm_reg;
        syl_reg    <= geom.spin[23:0] * ym_reg;
        syh_reg    <= geom.spin[47:24] * ym_reg;
        sx1_p2_reg <= sx1_p1_reg;
        sx2_p2_reg <= sx2_p1_reg;
        sxn_p2_reg <= sxn_p1_reg;
        syp_p2_reg <= syp_p1_reg;
        syn_p2_reg <= syn_p1_reg;

        // clamp the squared distance to its floor
        r1_reg            <= (r1_sum < DIST_FLOOR) ? DIST_FLOOR : r1_sum;
        r2_reg            <= (r2_sum < DIST_FLOOR) ? DIST_FLOOR : r2_sum;
        side_reg[0].md1   <= md1_reg;
        side_reg[0].md2   <= md2_reg;
        side_reg[0].my1   <= my1_reg;
        side_reg[0].my2   <= my2_reg;
        side_reg[0].gxs   <= gx_spin_full[62:28];
        side_reg[0].gys   <= gy_spin_full[62:28];
        side_reg[0].rsq   <= xsq_reg + ysq_reg;
        side_reg[0].sx1   <= sx1_p2_reg;
        side_reg[0].sx2   <= sx2_p2_reg;
        side_reg[0].sxn   <= sxn_p2_reg;
        side_reg[0].syp   <= syp_p2_reg;
        side_reg[0].syn   <= syn_p2_reg;
    end

    // hold the side data alongside the inverse pipe
    genvar i;
    generate
        for (i = 1; i <= INV_LAT; i++)
        begin : g_side
            always_ff @(posedge clk)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    endgenerate

    logic             inv_valid, inv2_valid;
    logic [INV_W-1:0] inv1, inv2;
    logic [IR3_W-1:0] ir1, ir2;

    tbeg_invdist u_inv1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v3_reg),
        .dist_sq   (r1_reg),
        .out_valid (inv_valid),
        .inv       (inv1),
        .ir3       (ir1)
    );

    tbeg_invdist u_inv2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v3_reg),
        .dist_sq   (r2_reg),
        .out_valid (inv2_valid),
        .inv       (inv2),
        .ir3       (ir2)
    );

    side_t sd;
    assign sd = side_reg[INV_LAT];

    // F1: partial products
    logic [63:0] a1l_reg, a1h_reg, a2l_reg, a2h_reg;
    logic [62:0] b1l_reg, b1h_reg, b2l_reg, b2h_reg;
    logic [36:0] p1l_reg, p1h_reg, p2l_reg, p2h_reg;
    logic [55:0] sl_reg, sh_reg;
    logic [34:0] gxs_f1_reg, gys_f1_reg;
    logic        sx1_f1_reg, sx2_f1_reg, sxn_f1_reg, syp_f1_reg, syn_f1_reg;
    logic        f1_reg;

    // F2: shifted terms
    logic [94:0] ax1_full, ax2_full;
    logic [93:0] ay1_full, ay2_full;
    logic [57:0] py1_full, py2_full;
    logic [79:0] ps_full;
    logic [58:0] ax1_reg, ax2_reg;
    logic [57:0] ay1_reg, ay2_reg;
    logic [33:0] py1_reg, py2_reg;
    logic [38:0] ps_reg;
    logic [34:0] gxs_f2_reg, gys_f2_reg;
    logic        sx1_f2_reg, sx2_f2_reg, sxn_f2_reg, syp_f2_reg, syn_f2_reg;
    logic        f2_reg;

    // F3: signed sums
    logic signed [63:0] tx1, tx2, txs, ty1, ty2, tys;
    logic signed [63:0] pot_sum_reg, gx_sum_reg, gy_sum_reg;
    logic               f3_reg;

    // output register
    logic [RESULT_WIDTH:0]  pot_c, gx_c, gy_c;
    logic [RESULT_WIDTH-1:0] potential_reg, accel_x_reg, accel_y_reg;
    logic                   saturated_reg;
    logic                   done_reg;

    assign ax1_full = (95'(a1h_reg) << 31) + 95'(a1l_reg);
    assign ax2_full = (95'(a2h_reg) << 31) + 95'(a2l_reg);
    assign ay1_full = (94'(b1h_reg) << 31) + 94'(b1l_reg);
    assign ay2_full = (94'(b2h_reg) << 31) + 94'(b2l_reg);
    assign py1_full = (58'(p1h_reg) << 21) + 58'(p1l_reg);
    assign py2_full = (58'(p2h_reg) << 21) + 58'(p2l_reg);
    assign ps_full  = (80'(sh_reg) << 24) + 80'(sl_reg);

    assign tx1 = sx1_f2_reg ? -$signed(64'(ax1_reg)) : $signed(64'(ax1_reg));
    assign tx2 = sx2_f2_reg ? -$signed(64'(ax2_reg)) : $signed(64'(ax2_reg));
    assign txs = sxn_f2_reg ? -$signed(64'(gxs_f2_reg)) : $signed(64'(gxs_f2_reg));
    assign ty1 = syp_f2_reg ? -$signed(64'(ay1_reg)) : $signed(64'(ay1_reg));
    assign ty2 = syp_f2_reg ? -$signed(64'(ay2_reg)) : $signed(64'(ay2_reg));
    assign tys = syn_f2_reg ? -$signed(64'(gys_f2_reg)) : $signed(64'(gys_f2_reg));

    assign pot_c = clip(pot_sum_reg);
    assign gx_c  = clip(gx_sum_reg);
    assign gy_c  = clip(gy_sum_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_reg   <= 1'b0;
            f2_reg   <= 1'b0;
            f3_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            f1_reg   <= inv_valid && inv2_valid;
            f2_reg   <= f1_reg;
            f3_reg   <= f2_reg;
            done_reg <= f3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a1l_reg    <= sd.md1 * ir1[30:0];
        a1h_reg    <= sd.md1 * ir1[61:31];
        a2l_reg    <= sd.md2 * ir2[30:0];
        a2h_reg    <= sd.md2 * ir2[61:31];
        b1l_reg    <= sd.my1 * ir1[30:0];
        b1h_reg    <= sd.my1 * ir1[61:31];
        b2l_reg    <= sd.my2 * ir2[30:0];
        b2h_reg    <= sd.my2 * ir2[61:31];
        p1l_reg    <= geom.m1 * inv1[20:0];
        p1h_reg    <= geom.m1 * inv1[41:21];
        p2l_reg    <= geom.m2 * inv2[20:0];
        p2h_reg    <= geom.m2 * inv2[41:21];
        sl_reg     <= geom.spin[23:0] * sd.rsq;
        sh_reg     <= geom.spin[47:24] * sd.rsq;
        gxs_f1_reg <= sd.gxs;
        gys_f1_reg <= sd.gys;
        sx1_f1_reg <= sd.sx1;
        sx2_f1_reg <= sd.sx2;
        sxn_f1_reg <= sd.sxn;
        syp_f1_reg <= sd.syp;
        syn_f1_reg <= sd.syn;

        ax1_reg    <= ax1_full[94:36];
        ax2_reg    <= ax2_full[94:36];
        ay1_reg    <= ay1_full[93:36];
        ay2_reg    <= ay2_full[93:36];
        py1_reg    <= py1_full[57:24];
        py2_reg    <= py2_full[57:24];
        ps_reg     <= ps_full[79:41];
        gxs_f2_reg <= gxs_f1_reg;
        gys_f2_reg <= gys_f1_reg;
        sx1_f2_reg <= sx1_f1_reg;
        sx2_f2_reg <= sx2_f1_reg;
        sxn_f2_reg <= sxn_f1_reg;
        syp_f2_reg <= syp_f1_reg;
        syn_f2_reg <= syn_f1_reg;

        gx_sum_reg  <= tx1 + tx2 + txs;
        gy_sum_reg  <= ty1 + ty2 + tys;
        pot_sum_reg <= -$signed(64'(py1_reg)) - $signed(64'(py2_reg))
                     - $signed(64'(ps_reg));

        potential_reg <= pot_c[RESULT_WIDTH-1:0];
        accel_x_reg   <= gx_c[RESULT_WIDTH-1:0];
        accel_y_reg   <= gy_c[RESULT_WIDTH-1:0];
        saturated_reg <= pot_c[RESULT_WIDTH] | gx_c[RESULT_WIDTH] | gy_c[RESULT_WIDTH];
    end

    assign done      = done_reg;
    assign potential = $signed(potential_reg);
    assign accel_x   = $signed(accel_x_reg);
    assign accel_y   = $signed(accel_y_reg);
    assign saturated = saturated_reg;

endmodule

>>> rtl/tbeg_cfg.sv
// Configuration registers and the sequencer that derives body positions and spin.
// Depends on tbeg_pkg.
module tbeg_cfg import tbeg_pkg::*; (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_WIDTH-1:0]       cfg_data,
    output logic                       busy,
    output geom_t                      geom
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PREP = 3'd1;
    localparam logic [2:0] ST_CUBE = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    localparam logic [6:0] DIV_FIRST  = 7'd76;
    localparam logic [6:0] SPIN_SHIFT = 7'd60;
    localparam logic [6:0] POS_BITS   = 7'd32;

    logic [2:0]               state_reg, state_next;
    logic [MASS_W-1:0]        mass_one_reg, mass_one_next;
    logic [MASS_W-1:0]        mass_two_reg, mass_two_next;
    logic [15:0]              sep_reg, sep_next;
    logic signed [POS_W-1:0]  body1_reg, body1_next;
    logic signed [POS_W-1:0]  body2_reg, body2_next;
    logic [SPIN_W-1:0]        spin_reg, spin_next;

    logic [16:0] msum_reg, msum_next;
    logic [31:0] dsq_reg, dsq_next;
    logic [31:0] num1_reg, num1_next;
    logic [31:0] num2_reg, num2_next;
    logic [47:0] dcube_reg, dcube_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [47:0] rem_s_reg, rem_s_next;
    logic [16:0] rem1_reg, rem1_next;
    logic [16:0] rem2_reg, rem2_next;
    logic [47:0] q_s_reg, q_s_next;
    logic [16:0] q1_reg, q1_next;
    logic [16:0] q2_reg, q2_next;
    logic        qsat_reg, qsat_next;

    logic [6:0]  cnt_off;
    logic        ns_bit, n1_bit, n2_bit;
    logic [48:0] rs_shift, rs_diff;
    logic [17:0] r1_shift, r2_shift, r1_diff, r2_diff;
    logic        qs_bit, q1_bit, q2_bit;
    logic        index_ok;

    assign cnt_off  = cnt_reg - SPIN_SHIFT;
    assign ns_bit   = (cnt_reg >= SPIN_SHIFT) ? msum_reg[cnt_off[4:0]] : 1'b0;
    assign n1_bit   = (cnt_reg < POS_BITS) ? num1_reg[cnt_reg[4:0]] : 1'b0;
    assign n2_bit   = (cnt_reg < POS_BITS) ? num2_reg[cnt_reg[4:0]] : 1'b0;
    assign rs_shift = {rem_s_reg, ns_bit};
    assign rs_diff  = rs_shift - {1'b0, dcube_reg};
    assign qs_bit   = (rs_shift >= {1'b0, dcube_reg});
    assign r1_shift = {rem1_reg, n1_bit};
    assign r2_shift = {rem2_reg, n2_bit};
    assign r1_diff  = r1_shift - {1'b0, msum_reg};
    assign r2_diff  = r2_shift - {1'b0, msum_reg};
    assign q1_bit   = (r1_shift >= {1'b0, msum_reg});
    assign q2_bit   = (r2_shift >= {1'b0, msum_reg});
    assign index_ok = (cfg_index == CFG_MASS_ONE) || (cfg_index == CFG_MASS_TWO)
                   || (cfg_index == CFG_SEPARATION);

    always_comb
    begin
        state_next    = state_reg;
        mass_one_next = mass_one_reg;
        mass_two_next = mass_two_reg;
        sep_next      = sep_reg;
        body1_next    = body1_reg;
        body2_next    = body2_reg;
        spin_next     = spin_reg;
        msum_next     = msum_reg;
        dsq_next      = dsq_reg;
        num1_next     = num1_reg;
        num2_next     = num2_reg;
        dcube_next    = dcube_reg;
        cnt_next      = cnt_reg;
        rem_s_next    = rem_s_reg;
        rem1_next     = rem1_reg;
        rem2_next     = rem2_reg;
        q_s_next      = q_s_reg;
        q1_next       = q1_reg;
        q2_next       = q2_reg;
        qsat_next     = qsat_reg;

        case (state_reg)
            ST_IDLE:
            begin
            end
            ST_PREP:
            begin
                msum_next  = {1'b0, mass_one_reg} + {1'b0, mass_two_reg};
                dsq_next   = sep_reg * sep_reg;
                num1_next  = mass_two_reg * sep_reg;
                num2_next  = mass_one_reg * sep_reg;
                state_next = ST_CUBE;
            end
            ST_CUBE:
            begin
                dcube_next = dsq_reg * sep_reg;
                cnt_next   = DIV_FIRST;
                rem_s_next = '0;
                rem1_next  = '0;
                rem2_next  = '0;
                q_s_next   = '0;
                q1_next    = '0;
                q2_next    = '0;
                qsat_next  = 1'b0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                // one quotient bit per cycle for all three divisions
                rem_s_next = qs_bit ? rs_diff[47:0] : rs_shift[47:0];
                rem1_next  = q1_bit ? r1_diff[16:0] : r1_shift[16:0];
                rem2_next  = q2_bit ? r2_diff[16:0] : r2_shift[16:0];
                q_s_next   = {q_s_reg[46:0], qs_bit};
                q1_next    = {q1_reg[15:0], q1_bit};
                q2_next    = {q2_reg[15:0], q2_bit};
                qsat_next  = qsat_reg | q_s_reg[47];
                cnt_next   = cnt_reg - 7'd1;
                if (cnt_reg == 7'd0)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (msum_reg == 17'd0)
                begin
                    body1_next = '0;
                    body2_next = '0;
                    spin_next  = '0;
                end
                else
                begin
                    body1_next = $signed(17'd0 - q1_reg);
                    body2_next = $signed(q2_reg);
                    if ((dcube_reg == 48'd0) || qsat_reg)
                    begin
                        spin_next = SPIN_MAX;
                    end
                    else
                    begin
                        spin_next = q_s_reg;
                    end
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // a write to a valid index restarts the derivation from the new register values
        if (cfg_write && index_ok)
        begin
            state_next = ST_PREP;
            case (cfg_index)
                CFG_MASS_ONE:   mass_one_next = cfg_data;
                CFG_MASS_TWO:   mass_two_next = cfg_data;
                CFG_SEPARATION: sep_next      = cfg_data;
                default:        sep_next      = sep_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            mass_one_reg <= 16'd256;
            mass_two_reg <= 16'd256;
            sep_reg      <= 16'd4096;
            body1_reg    <= '0;
            body2_reg    <= '0;
            spin_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            mass_one_reg <= mass_one_next;
            mass_two_reg <= mass_two_next;
            sep_reg      <= sep_next;
            body1_reg    <= body1_next;
            body2_reg    <= body2_next;
            spin_reg     <= spin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        msum_reg  <= msum_next;
        dsq_reg   <= dsq_next;
        num1_reg  <= num1_next;
        num2_reg  <= num2_next;
        dcube_reg <= dcube_next;
        cnt_reg   <= cnt_next;
        rem_s_reg <= rem_s_next;
        rem1_reg  <= rem1_next;
        rem2_reg  <= rem2_next;
        q_s_reg   <= q_s_next;
        q1_reg    <= q1_next;
        q2_reg    <= q2_next;
        qsat_reg  <= qsat_next;
    end

    assign busy            = (state_reg != ST_IDLE);
    assign geom.m1         = mass_one_reg;
    assign geom.m2         = mass_two_reg;
    assign geom.body_one_x = body1_reg;
    assign geom.body_two_x = body2_reg;
    assign geom.spin       = spin_reg;

endmodule

>>> rtl/tbeg_invdist.sv
// Pipelined inverse distance and inverse cube from a squared distance:
// square root, reciprocal and two split multiplications. Depends on tbeg_pkg.
module tbeg_invdist import tbeg_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [DSQ_W-1:0] dist_sq,
    output logic             out_valid,
    output logic [INV_W-1:0] inv,
    output logic [IR3_W-1:0] ir3
);

    localparam int RV_W = DSQ_W + 16;
    localparam int RR_W = RV_W + 1;

    logic [RV_W-1:0]   rv_reg  [0:ISQ_STAGES];
    logic [RR_W-1:0]   rr_reg  [0:ISQ_STAGES];
    logic              rval_reg[0:ISQ_STAGES];

    logic [ROOT_W-1:0] dv_rem_reg[0:DIV_STAGES];
    logic [ROOT_W-1:0] dv_s_reg  [0:DIV_STAGES];
    logic [INV_W-1:0]  dv_q_reg  [0:DIV_STAGES];
    logic              dval_reg  [0:DIV_STAGES];

    // stage zero is the unregistered input
    assign rv_reg[0]   = {dist_sq, 16'd0};
    assign rr_reg[0]   = '0;
    assign rval_reg[0] = in_valid;

    genvar j;
    generate
        for (j = 0; j < ISQ_STAGES; j++)
        begin : g_root
            localparam logic [RR_W-1:0] BITV = RR_W'(1) << (2 * (ISQ_STAGES - 1 - j));
            logic [RR_W-1:0] trial;
            logic [RR_W-1:0] r_next;
            logic [RV_W-1:0] v_next;

            always_comb
            begin
                trial = rr_reg[j] + BITV;
                if ({1'b0, rv_reg[j]} >= trial)
                begin
                    v_next = rv_reg[j] - trial[RV_W-1:0];
                    r_next = (rr_reg[j] >> 1) + BITV;
                end
                else
                begin
                    v_next = rv_reg[j];
                    r_next = rr_reg[j] >> 1;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    rval_reg[j+1] <= 1'b0;
                end
                else
                begin
                    rval_reg[j+1] <= rval_reg[j];
                end
            end

            always_ff @(posedge clk)
            begin
                rv_reg[j+1] <= v_next;
                rr_reg[j+1] <= r_next;
            end
        end
    endgenerate

    // 2^52 / root; the leading remainder is 2^10, below every possible root
    assign dv_rem_reg[0] = ROOT_W'(1024);
    assign dv_s_reg[0]   = rr_reg[ISQ_STAGES][ROOT_W-1:0];
    assign dv_q_reg[0]   = '0;
    assign dval_reg[0]   = rval_reg[ISQ_STAGES];

    genvar k;
    generate
        for (k = 0; k < DIV_STAGES; k++)
        begin : g_div
            logic [ROOT_W:0]   t1, t2;
            logic [ROOT_W-1:0] r1, r2;
            logic              b1, b2;

            always_comb
            begin
                t1 = {dv_rem_reg[k], 1'b0};
                b1 = (t1 >= {1'b0, dv_s_reg[k]});
                r1 = b1 ? ROOT_W'(t1 - {1'b0, dv_s_reg[k]}) : t1[ROOT_W-1:0];
                t2 = {r1, 1'b0};
                b2 = (t2 >= {1'b0, dv_s_reg[k]});
                r2 = b2 ? ROOT_W'(t2 - {1'b0, dv_s_reg[k]}) : t2[ROOT_W-1:0];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    dval_reg[k+1] <= 1'b0;
                end
                else
                begin
                    dval_reg[k+1] <= dval_reg[k];
                end
            end

            always_ff @(posedge clk)
            begin
                dv_rem_reg[k+1] <= r2;
                dv_s_reg[k+1]   <= dv_s_reg[k];
                dv_q_reg[k+1]   <= {dv_q_reg[k][INV_W-3:0], b1, b2};
            end
        end
    endgenerate

    logic [INV_W-1:0] inv_q;
    logic [20:0]      iq_hi, iq_lo;
    assign inv_q = dv_q_reg[DIV_STAGES];
    assign iq_hi = inv_q[41:21];
    assign iq_lo = inv_q[20:0];

    // inv squared from 21-bit halves
    logic [41:0]      mhh_reg, mhl_reg, mll_reg;
    logic [INV_W-1:0] inv_a_reg;
    logic             va_reg;

    logic [83:0]      sq_full;
    logic [51:0]      t_reg;
    logic [INV_W-1:0] inv_b_reg;
    logic             vb_reg;

    logic [20:0]      ib_hi, ib_lo;
    logic [46:0]      phh_reg, phl_reg, plh_reg, pll_reg;
    logic [INV_W-1:0] inv_c_reg;
    logic             vc_reg;

    logic [93:0]      cube_full;
    logic [IR3_W-1:0] ir3_reg;
    logic [INV_W-1:0] inv_d_reg;
    logic             vd_reg;

    assign sq_full   = (84'(mhh_reg) << 42) + (84'(mhl_reg) << 22) + 84'(mll_reg);
    assign ib_hi     = inv_b_reg[41:21];
    assign ib_lo     = inv_b_reg[20:0];
    assign cube_full = (94'(phh_reg) << 47) + (94'(phl_reg) << 26)
                     + (94'(plh_reg) << 21) + 94'(pll_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end
        else
        begin
            va_reg <= dval_reg[DIV_STAGES];
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mhh_reg   <= iq_hi * iq_hi;
        mhl_reg   <= iq_hi * iq_lo;
        mll_reg   <= iq_lo * iq_lo;
        inv_a_reg <= inv_q;

        t_reg     <= sq_full[83:32];
        inv_b_reg <= inv_a_reg;

        phh_reg   <= t_reg[51:26] * ib_hi;
        phl_reg   <= t_reg[51:26] * ib_lo;
        plh_reg   <= t_reg[25:0] * ib_hi;
        pll_reg   <= t_reg[25:0] * ib_lo;
        inv_c_reg <= inv_b_reg;

        ir3_reg   <= cube_full[93:32];
        inv_d_reg <= inv_c_reg;
    end

    assign out_valid = vd_reg;
    assign inv       = inv_d_reg;
    assign ir3       = ir3_reg;

endmodule
